>>> src/spq_pkg.sv
package spq_pkg;

	localparam int SPQ_DEPTH = 16;
	localparam int TAG_W     = 16;
	localparam int PRIO_W    = 8;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// One slot of the sorted row
	typedef struct packed {
		logic              valid;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} spq_entry_t;

	// Command broadcast to every cell for one transaction
	typedef struct packed {
		logic              enq;
		logic              deq;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} spq_cmd_t;

endpackage

>>> src/spq_cell.sv
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  spq_cmd_t   cmd,
	input  spq_entry_t left_entry,
	input  logic       left_yield,
	input  spq_entry_t right_entry,
	output spq_entry_t entry,
	output logic       yield
);

	logic              valid_q;
	logic [TAG_W-1:0]  tag_q;
	logic [PRIO_W-1:0] prio_q;
	spq_entry_t        entry_q;
	spq_entry_t        entry_d;

	always_comb begin
		entry_q.valid = valid_q;
		entry_q.tag   = tag_q;
		entry_q.prio  = prio_q;
	end

	// Yield the slot when empty or when the held entry sorts strictly after the new one
	assign yield = !entry_q.valid || (entry_q.prio > cmd.prio);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (cmd.enq) begin
			if (left_yield) begin
				entry_d = left_entry;
			end else if (yield) begin
				entry_d.valid = 1'b1;
				entry_d.tag   = cmd.tag;
				entry_d.prio  = cmd.prio;
			end
		end else if (cmd.deq) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q  <= entry_d.tag;
		prio_q <= entry_d.prio;
	end

endmodule

>>> src/stable_priority_queue.sv
// Sorted priority queue built as a row of DEPTH cells, front at cell 0.
// Command channel: present mode, member_tag and priority_req with start high;
// the transaction is taken on any edge where start is high and busy is low.
// busy stays low: the row absorbs one enqueue or dequeue every cycle.
// mode selects enqueue (insert after every held entry of lower or equal
// priority number) or dequeue (remove and return the front entry).
// Result channel: in the cycle after each accepted command, done pulses
// for one cycle with out_valid, out_tag, out_priority, now_empty and
// rejected_full. The receiver cannot stall; sample the result on that edge.
// Throughput is one command per cycle, set by each cell doing a single
// priority compare against the broadcast command and loading from itself,
// its left or its right neighbor, or the command's tag and priority.
// An enqueue into a full row is dropped and flagged with rejected_full.
// Reset clears all cell valid bits (queue empty) and the done strobe;
// tag and priority storage is left as is.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [TAG_W-1:0]  member_tag,
	input  logic [PRIO_W-1:0] priority_req,
	output logic              done,
	output logic              out_valid,
	output logic [TAG_W-1:0]  out_tag,
	output logic [PRIO_W-1:0] out_priority,
	output logic              now_empty,
	output logic              rejected_full
);

	spq_entry_t             entries [DEPTH];
	logic       [DEPTH-1:0] yields;
	logic       [DEPTH-1:0] vld;
	spq_cmd_t               cmd;
	spq_entry_t             blank;

	logic accept;
	logic is_enq;
	logic is_deq;
	logic full;
	logic empty;

	logic              done_q;
	logic              out_valid_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [PRIO_W-1:0] out_priority_q;
	logic              now_empty_q;
	logic              rejected_full_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_enq = accept && (mode == MODE_ENQ);
	assign is_deq = accept && (mode == MODE_DEQ);

	// Occupancy is the thermometer of cell valid bits
	assign full  = vld[DEPTH-1];
	assign empty = !vld[0];

	assign blank = '0;

	// Broadcast the command; drop an enqueue when full, ignore a dequeue when empty
	always_comb begin
		cmd.enq  = is_enq && !full;
		cmd.deq  = is_deq && !empty;
		cmd.tag  = member_tag;
		cmd.prio = priority_req;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			spq_entry_t left_e;
			spq_entry_t right_e;
			logic       left_y;

			if (gi == 0) begin : g_head
				assign left_e = blank;
				assign left_y = 1'b0;
			end else begin : g_mid
				assign left_e = entries[gi-1];
				assign left_y = yields[gi-1];
			end

			if (gi == DEPTH-1) begin : g_tail
				assign right_e = blank;
			end else begin : g_body
				assign right_e = entries[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.left_entry  (left_e),
				.left_yield  (left_y),
				.right_entry (right_e),
				.entry       (entries[gi]),
				.yield       (yields[gi])
			);

			assign vld[gi] = entries[gi].valid;
		end
	endgenerate

	// Hold the done strobe for exactly one cycle per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// Capture the result fields; the front cell still holds the entry being removed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_q     <= cmd.enq || cmd.deq;
			out_tag_q       <= cmd.deq ? entries[0].tag : '0;
			out_priority_q  <= cmd.deq ? entries[0].prio : '0;
			rejected_full_q <= is_enq && full;
			if (cmd.enq) begin
				now_empty_q <= 1'b0;
			end else if (cmd.deq) begin
				now_empty_q <= !vld[1];
			end else begin
				now_empty_q <= empty;
			end
		end
	end

	assign done          = done_q;
	assign out_valid     = out_valid_q;
	assign out_tag       = out_tag_q;
	assign out_priority  = out_priority_q;
	assign now_empty     = now_empty_q;
	assign rejected_full = rejected_full_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after accepted command");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without a command");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("valid cells are not packed toward the front");

	a_reject_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_ENQ && !full |=> !rejected_full && out_valid)
		else $error("enqueue rejected while space was left");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid && rejected_full))
		else $error("result both valid and rejected");

endmodule
